// ===== rtl/core/pps_pkg.sv =====
// ============================================================================
// pps_pkg
// Shared types and codepoint range constants for the pretokenizer piece
// splitter.
// ============================================================================
package pps_pkg;

    localparam int unsigned CP_W = 21;

    // Character class carried on the result beat
    typedef enum logic [1:0] {
        KIND_WS  = 2'd0,
        KIND_LET = 2'd1,
        KIND_DIG = 2'd2,
        KIND_OTH = 2'd3
    } kind_t;

    // Classifier result handed to the split state machine
    typedef struct packed {
        kind_t kind;
        logic  is_nl;     // LF or CR
        logic  is_space;  // plain ASCII space
    } pps_class_t;

    // Single codepoints
    localparam logic [CP_W-1:0] CP_TAB     = 21'h00009;
    localparam logic [CP_W-1:0] CP_LF      = 21'h0000A;
    localparam logic [CP_W-1:0] CP_VT      = 21'h0000B;
    localparam logic [CP_W-1:0] CP_FF      = 21'h0000C;
    localparam logic [CP_W-1:0] CP_CR      = 21'h0000D;
    localparam logic [CP_W-1:0] CP_SPACE   = 21'h00020;
    localparam logic [CP_W-1:0] CP_IDSP    = 21'h03000;

    // Digit ranges
    localparam logic [CP_W-1:0] CP_DIG_LO  = 21'h00030;
    localparam logic [CP_W-1:0] CP_DIG_HI  = 21'h00039;
    localparam logic [CP_W-1:0] CP_FWD_LO  = 21'h0FF10;
    localparam logic [CP_W-1:0] CP_FWD_HI  = 21'h0FF19;

    // Letter ranges
    localparam logic [CP_W-1:0] CP_LC_LO   = 21'h00061;
    localparam logic [CP_W-1:0] CP_LC_HI   = 21'h0007A;
    localparam logic [CP_W-1:0] CP_UC_LO   = 21'h00041;
    localparam logic [CP_W-1:0] CP_UC_HI   = 21'h0005A;
    localparam logic [CP_W-1:0] CP_FWU_LO  = 21'h0FF21;
    localparam logic [CP_W-1:0] CP_FWU_HI  = 21'h0FF3A;
    localparam logic [CP_W-1:0] CP_FWL_LO  = 21'h0FF41;
    localparam logic [CP_W-1:0] CP_FWL_HI  = 21'h0FF5A;
    localparam logic [CP_W-1:0] CP_NONASC  = 21'h00080;

    // Punctuation table ranges
    localparam logic [CP_W-1:0] CP_CJKP_LO = 21'h03001;
    localparam logic [CP_W-1:0] CP_CJKP_HI = 21'h0303F;
    localparam logic [CP_W-1:0] CP_FP0_LO  = 21'h0FF00;
    localparam logic [CP_W-1:0] CP_FP0_HI  = 21'h0FF0F;
    localparam logic [CP_W-1:0] CP_FP1_LO  = 21'h0FF1A;
    localparam logic [CP_W-1:0] CP_FP1_HI  = 21'h0FF20;
    localparam logic [CP_W-1:0] CP_FP2_LO  = 21'h0FF3B;
    localparam logic [CP_W-1:0] CP_FP2_HI  = 21'h0FF40;
    localparam logic [CP_W-1:0] CP_FP3_LO  = 21'h0FF5B;
    localparam logic [CP_W-1:0] CP_FP3_HI  = 21'h0FF65;
    localparam logic [CP_W-1:0] CP_SYM_LO  = 21'h1F000;

endpackage

// ===== rtl/core/pps_classify.sv =====
// ============================================================================
// pps_classify
// Combinational codepoint classifier: whitespace, letter, digit or other,
// plus the newline and plain-space flags the split rules need.
// ============================================================================
module pps_classify
    import pps_pkg::*;
(
    input  logic [CP_W-1:0] code_point,
    output pps_class_t      cls
);

    logic is_ws;
    logic is_nl;
    logic is_dig;
    logic is_punct;
    logic is_let;

    // Range compares
    always_comb begin
        is_nl  = (code_point == CP_LF) || (code_point == CP_CR);
        is_ws  = (code_point == CP_SPACE) || (code_point == CP_TAB) ||
                 (code_point == CP_VT) || (code_point == CP_FF) ||
                 is_nl || (code_point == CP_IDSP);
        is_dig = ((code_point >= CP_DIG_LO) && (code_point <= CP_DIG_HI)) ||
                 ((code_point >= CP_FWD_LO) && (code_point <= CP_FWD_HI));
        is_punct = ((code_point >= CP_CJKP_LO) && (code_point <= CP_CJKP_HI)) ||
                   ((code_point >= CP_FP0_LO) && (code_point <= CP_FP0_HI)) ||
                   ((code_point >= CP_FP1_LO) && (code_point <= CP_FP1_HI)) ||
                   ((code_point >= CP_FP2_LO) && (code_point <= CP_FP2_HI)) ||
                   ((code_point >= CP_FP3_LO) && (code_point <= CP_FP3_HI)) ||
                   (code_point >= CP_SYM_LO);
        // Non-ASCII falls to letter unless claimed by another class
        is_let = ((code_point >= CP_LC_LO) && (code_point <= CP_LC_HI)) ||
                 ((code_point >= CP_UC_LO) && (code_point <= CP_UC_HI)) ||
                 ((code_point >= CP_FWU_LO) && (code_point <= CP_FWU_HI)) ||
                 ((code_point >= CP_FWL_LO) && (code_point <= CP_FWL_HI)) ||
                 ((code_point >= CP_NONASC) && !is_ws && !is_dig && !is_punct);
    end

    // Priority: whitespace, letter, digit, other
    always_comb begin
        if (is_ws) begin
            cls.kind = KIND_WS;
        end else if (is_let) begin
            cls.kind = KIND_LET;
        end else if (is_dig) begin
            cls.kind = KIND_DIG;
        end else begin
            cls.kind = KIND_OTH;
        end
        cls.is_nl    = is_nl;
        cls.is_space = (code_point == CP_SPACE);
    end

endmodule

// ===== rtl/core/pps_split_fsm.sv =====
// ============================================================================
// pps_split_fsm
// Split mode register and piece-start decision. The mode advances once per
// codepoint moved to the result register and drops to idle after a last beat.
// ============================================================================
module pps_split_fsm
    import pps_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       advance,
    input  pps_class_t cls,
    input  logic       text_last,
    output logic       piece_start
);

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_SPACE  = 3'd1,
        MODE_WS     = 3'd2,
        MODE_LET    = 3'd3,
        MODE_PUNCT  = 3'd4,
        MODE_NLTAIL = 3'd5,
        MODE_SPUNCT = 3'd6
    } mode_t;

    mode_t mode_reg;
    mode_t mode_next;
    mode_t cont_mode;
    mode_t open_mode;
    logic  start;

    // Continue the current piece, or flag a new one
    always_comb begin
        start     = 1'b0;
        cont_mode = MODE_IDLE;
        case (mode_reg)
            MODE_SPACE: begin
                if (cls.kind == KIND_WS) begin
                    cont_mode = MODE_WS;
                end else if (cls.kind == KIND_LET) begin
                    cont_mode = MODE_LET;
                end else if (cls.kind == KIND_OTH) begin
                    cont_mode = MODE_SPUNCT;
                end else begin
                    start = 1'b1;
                end
            end
            MODE_WS: begin
                if (cls.kind == KIND_WS) cont_mode = MODE_WS; else start = 1'b1;
            end
            MODE_LET: begin
                if (cls.kind == KIND_LET) cont_mode = MODE_LET; else start = 1'b1;
            end
            MODE_PUNCT: begin
                if (cls.kind == KIND_OTH) begin
                    cont_mode = MODE_PUNCT;
                end else if (cls.is_nl) begin
                    cont_mode = MODE_NLTAIL;
                end else begin
                    start = 1'b1;
                end
            end
            MODE_NLTAIL: begin
                if (cls.is_nl) cont_mode = MODE_NLTAIL; else start = 1'b1;
            end
            MODE_SPUNCT: begin
                if (cls.kind == KIND_OTH) cont_mode = MODE_SPUNCT; else start = 1'b1;
            end
            default: begin
                start = 1'b1;
            end
        endcase
    end

    // Mode taken on when this codepoint opens a piece
    always_comb begin
        case (cls.kind)
            KIND_WS:  open_mode = cls.is_space ? MODE_SPACE : MODE_WS;
            KIND_LET: open_mode = MODE_LET;
            KIND_DIG: open_mode = MODE_IDLE;
            default:  open_mode = MODE_PUNCT;
        endcase
    end

    always_comb begin
        if (text_last) begin
            mode_next = MODE_IDLE;
        end else if (start) begin
            mode_next = open_mode;
        end else begin
            mode_next = cont_mode;
        end
    end

    assign piece_start = start;

    // Mode register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_IDLE;
        end else if (advance) begin
            mode_reg <= mode_next;
        end
    end

endmodule

// ===== rtl/core/pretokenizer_piece_splitter.sv =====
// Path: an accepted input beat is held in the input register, then in the result register, on its way to m_.
// Throughput: one codepoint per cycle while m_tready stays high, with the mode
// register updated on each move from the input register to the result register.
// Reset: aresetn low for one clock empties both registers and returns the
// split mode to idle; the next codepoint then opens a piece.
// ============================================================================
// pretokenizer_piece_splitter
// Streaming pretokenizer: classifies each codepoint and marks piece starts.
// ============================================================================
module pretokenizer_piece_splitter
    import pps_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [20:0] code_point, [23:21] zero
    input  logic        s_tlast,   // text_last
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [0] piece_start, [7:1] zero
    output logic [1:0]  m_tuser,   // [1:0] char_kind
    output logic        m_tlast    // segment_end
);

    logic            in_valid_reg;
    logic [CP_W-1:0] in_cp_reg;
    logic            in_last_reg;

    logic            out_valid_reg;
    logic            out_start_reg;
    kind_t           out_kind_reg;
    logic            out_last_reg;

    logic            s_fire;
    logic            advance;
    pps_class_t      cls;
    logic            piece_start;

    // Handshake: input stage drains when the result register is free
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_fire) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_cp_reg   <= s_tdata[CP_W-1:0];
            in_last_reg <= s_tlast;
        end
    end

    pps_classify u_classify (
        .code_point (in_cp_reg),
        .cls        (cls)
    );

    pps_split_fsm u_split_fsm (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (advance),
        .cls         (cls),
        .text_last   (in_last_reg),
        .piece_start (piece_start)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_start_reg <= piece_start;
            out_kind_reg  <= cls.kind;
            out_last_reg  <= in_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_start_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ===== rtl/core/pps_checker.sv =====
// ============================================================================
// pps_checker
// Port-level checks on the piece splitter result stream, bound to the top.
// ============================================================================
module pps_checker
    import pps_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    // Nothing is presented right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result beat valid after reset");

    // A stalled result beat holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) &&
        $stable(m_tuser) && $stable(m_tlast))
        else $error("stalled result beat changed");

    // Every digit is a piece of its own
    a_digit_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_DIG) |-> m_tdata[0])
        else $error("digit without piece start");

    // The beat right after a segment end opens a piece
    a_segment_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) ##1 (m_tvalid && m_tready) |-> m_tdata[0])
        else $error("segment did not restart with a piece start");

    // Padding bits stay zero
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[7:1] == 7'd0))
        else $error("nonzero padding in result beat");

endmodule

bind pretokenizer_piece_splitter pps_checker u_pps_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ===== tb/tb_pretokenizer_piece_splitter.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_pretokenizer_piece_splitter
// Self-checking bench for the streaming piece splitter. A directed table of
// codepoints covers the class boundaries and the split rules. Random text
// segments then run under several idle/stall patterns. Every accepted input
// beat is run through a local model of the classifier and the split mode.
// Each result beat is checked field by field against the oldest prediction.
// ============================================================================
module tb_pretokenizer_piece_splitter;
    import pps_pkg::*;

    localparam int RANDOM_ITEMS = 1750;
    localparam int LONG_HOLD    = 400;
    localparam int QUIET_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 8;

    // Split modes of the local model
    typedef enum logic [2:0] {
        SM_IDLE        = 3'd0,
        SM_SPACE       = 3'd1,
        SM_WS_RUN      = 3'd2,
        SM_LETTER_RUN  = 3'd3,
        SM_PUNCT_RUN   = 3'd4,
        SM_NL_TAIL     = 3'd5,
        SM_SPACE_PUNCT = 3'd6
    } split_mode_e;

    typedef struct packed {
        logic  start;
        kind_t kind;
        logic  seg_end;
    } piece_res_t;

    typedef struct packed {
        logic [20:0] cp;
        logic        last;
        logic        typed;   // row carries a hand-written expectation
        piece_res_t  res;
    } dir_row_t;

    localparam piece_res_t NO_RES = '0;

    // Directed stimulus: class boundaries, extremes and the split rules
    localparam int DIR_ROWS = 26;
    localparam dir_row_t DIRECTED [DIR_ROWS] = '{
        '{21'h00061, 1'b0, 1'b1, '{1'b1, KIND_LET, 1'b0}},  // first letter after reset
        '{21'h00062, 1'b0, 1'b0, NO_RES},
        '{21'h00020, 1'b0, 1'b0, NO_RES},
        '{21'h00037, 1'b0, 1'b1, '{1'b1, KIND_DIG, 1'b0}},  // space then digit
        '{21'h00038, 1'b0, 1'b1, '{1'b1, KIND_DIG, 1'b0}},  // each digit alone
        '{21'h00020, 1'b1, 1'b1, '{1'b1, KIND_WS, 1'b1}},   // space closes segment
        '{21'h00020, 1'b0, 1'b0, NO_RES},
        '{21'h00078, 1'b0, 1'b0, NO_RES},
        '{21'h00021, 1'b0, 1'b0, NO_RES},
        '{21'h0003F, 1'b0, 1'b0, NO_RES},
        '{21'h0000A, 1'b0, 1'b0, NO_RES},
        '{21'h0000D, 1'b0, 1'b0, NO_RES},
        '{21'h00009, 1'b0, 1'b0, NO_RES},
        '{21'h03000, 1'b0, 1'b0, NO_RES},
        '{21'h00020, 1'b0, 1'b0, NO_RES},
        '{21'h00000, 1'b0, 1'b1, '{1'b1, KIND_OTH, 1'b0}},  // lowest codepoint
        '{21'h1FFFF, 1'b0, 1'b0, NO_RES},
        '{21'h10FFFF, 1'b0, 1'b0, NO_RES},
        '{21'h0D800, 1'b0, 1'b0, NO_RES},                   // surrogates are letters
        '{21'h0DFFF, 1'b0, 1'b0, NO_RES},
        '{21'h0FF10, 1'b0, 1'b0, NO_RES},
        '{21'h0FF19, 1'b1, 1'b0, NO_RES},
        '{21'h00020, 1'b0, 1'b0, NO_RES},
        '{21'h03001, 1'b0, 1'b0, NO_RES},
        '{21'h0000A, 1'b1, 1'b0, NO_RES},
        '{21'h1FFFFF, 1'b1, 1'b1, '{1'b1, KIND_OTH, 1'b1}}  // all ones, past Unicode
    };

    // Codepoints at or next to range edges
    localparam int N_EDGES = 20;
    localparam logic [20:0] RANGE_EDGES [N_EDGES] = '{
        21'h0002F, 21'h0003A, 21'h00040, 21'h0005B, 21'h00060, 21'h0007B,
        21'h0007F, 21'h00080, 21'h02FFF, 21'h03040, 21'h0FEFF, 21'h0FF1A,
        21'h0FF20, 21'h0FF3B, 21'h0FF40, 21'h0FF65, 21'h0FF66, 21'h1EFFF,
        21'h110000, 21'h0E000
    };

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;   // [20:0] code_point, [23:21] zero
    logic        s_tlast  = 1'b0; // text_last
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;         // [0] piece_start, [7:1] zero
    logic [1:0]  m_tuser;         // [1:0] char_kind
    logic        m_tlast;         // segment_end

    // Side info traveling with the input beat
    logic        beat_typed     = 1'b0;
    piece_res_t  beat_typed_res = '0;

    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    logic        long_hold_req  = 1'b0;
    logic        long_hold_taken = 1'b0;
    int          hold_left      = 0;

    piece_res_t  piece_q [$];
    split_mode_e split_st = SM_IDLE;
    int          mismatches = 0;
    int          quiet_cycles = 0;

    pretokenizer_piece_splitter dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #5 aclk = ~aclk;

    // Character classes
    function automatic logic is_newline(input logic [20:0] cp);
        return cp == 21'h0A || cp == 21'h0D;
    endfunction

    function automatic kind_t kind_of(input logic [20:0] cp);
        logic ws;
        logic dig;
        logic punct;
        logic let_ascii;
        ws = cp == 21'h20 || cp == 21'h09 || cp == 21'h0B || cp == 21'h0C ||
             is_newline(cp) || cp == 21'h3000;
        dig = (cp >= 21'h30 && cp <= 21'h39) || (cp >= 21'hFF10 && cp <= 21'hFF19);
        punct = (cp >= 21'h3001 && cp <= 21'h303F) || (cp >= 21'hFF00 && cp <= 21'hFF0F) ||
                (cp >= 21'hFF1A && cp <= 21'hFF20) || (cp >= 21'hFF3B && cp <= 21'hFF40) ||
                (cp >= 21'hFF5B && cp <= 21'hFF65) || cp >= 21'h1F000;
        let_ascii = (cp >= 21'h61 && cp <= 21'h7A) || (cp >= 21'h41 && cp <= 21'h5A) ||
                    (cp >= 21'hFF21 && cp <= 21'hFF3A) || (cp >= 21'hFF41 && cp <= 21'hFF5A);
        if (ws)
            return KIND_WS;
        if (let_ascii || (cp >= 21'h80 && !dig && !punct))
            return KIND_LET;
        if (dig)
            return KIND_DIG;
        return KIND_OTH;
    endfunction

    // Piece decision for one codepoint; also yields the next split mode
    function automatic piece_res_t split_piece(input logic [20:0] cp, input logic last,
                                               input split_mode_e cur,
                                               output split_mode_e nxt);
        kind_t       k;
        logic        opens;
        split_mode_e nm;
        piece_res_t  r;
        k     = kind_of(cp);
        opens = 1'b0;
        nm    = SM_IDLE;
        case (cur)
            SM_SPACE: begin
                if (k == KIND_WS) nm = SM_WS_RUN;
                else if (k == KIND_LET) nm = SM_LETTER_RUN;
                else if (k == KIND_OTH) nm = SM_SPACE_PUNCT;
                else opens = 1'b1;
            end
            SM_WS_RUN: begin
                if (k == KIND_WS) nm = SM_WS_RUN; else opens = 1'b1;
            end
            SM_LETTER_RUN: begin
                if (k == KIND_LET) nm = SM_LETTER_RUN; else opens = 1'b1;
            end
            SM_PUNCT_RUN: begin
                if (k == KIND_OTH) nm = SM_PUNCT_RUN;
                else if (is_newline(cp)) nm = SM_NL_TAIL;
                else opens = 1'b1;
            end
            SM_NL_TAIL: begin
                if (is_newline(cp)) nm = SM_NL_TAIL; else opens = 1'b1;
            end
            SM_SPACE_PUNCT: begin
                if (k == KIND_OTH) nm = SM_SPACE_PUNCT; else opens = 1'b1;
            end
            default: opens = 1'b1;
        endcase
        // Fresh piece: mode follows the opening codepoint
        if (opens) begin
            case (k)
                KIND_WS:  nm = (cp == 21'h20) ? SM_SPACE : SM_WS_RUN;
                KIND_LET: nm = SM_LETTER_RUN;
                KIND_DIG: nm = SM_IDLE;
                default:  nm = SM_PUNCT_RUN;
            endcase
        end
        nxt       = last ? SM_IDLE : nm;
        r.start   = opens;
        r.kind    = k;
        r.seg_end = last;
        return r;
    endfunction

    // Text-like codepoint mix, with a share of raw 21-bit noise
    function automatic logic [20:0] text_code_point();
        int          pick;
        logic [20:0] cp;
        pick = $urandom_range(99);
        if (pick < 22) begin
            cp = 21'h20;
        end else if (pick < 27) begin
            cp = $urandom_range(1) ? 21'h0A : 21'h0D;
        end else if (pick < 30) begin
            case ($urandom_range(3))
                0: cp = 21'h09;
                1: cp = 21'h0B;
                2: cp = 21'h0C;
                default: cp = 21'h3000;
            endcase
        end else if (pick < 48) begin
            cp = $urandom_range(1) ? 21'($urandom_range(21'h7A, 21'h61))
                                   : 21'($urandom_range(21'h5A, 21'h41));
        end else if (pick < 56) begin
            case ($urandom_range(3))
                0: cp = 21'($urandom_range(21'h2FFF, 21'h80));
                1: cp = 21'($urandom_range(21'hDFFF, 21'hD800));
                2: cp = 21'($urandom_range(21'hFF3A, 21'hFF21));
                default: cp = 21'($urandom_range(21'hFF5A, 21'hFF41));
            endcase
        end else if (pick < 64) begin
            cp = $urandom_range(1) ? 21'($urandom_range(21'h39, 21'h30))
                                   : 21'($urandom_range(21'hFF19, 21'hFF10));
        end else if (pick < 76) begin
            do cp = 21'($urandom_range(21'h7E, 21'h21));
            while (kind_of(cp) != KIND_OTH);
        end else if (pick < 82) begin
            case ($urandom_range(4))
                0: cp = 21'($urandom_range(21'h303F, 21'h3001));
                1: cp = 21'($urandom_range(21'hFF0F, 21'hFF00));
                2: cp = 21'($urandom_range(21'hFF20, 21'hFF1A));
                3: cp = 21'($urandom_range(21'hFF65, 21'hFF5B));
                default: cp = 21'($urandom_range(21'h1FFFFF, 21'h1F000));
            endcase
        end else if (pick < 86) begin
            cp = 21'($urandom_range(21'h1F, 21'h00));
        end else if (pick < 91) begin
            cp = RANGE_EDGES[$urandom_range(N_EDGES - 1)];
        end else begin
            cp = 21'($urandom_range(21'h1FFFFF, 21'h0));
        end
        return cp;
    endfunction

    // Offer one beat and hold it until accepted
    task automatic send_code_point(input logic [20:0] cp, input logic last,
                                   input logic typed, input piece_res_t typed_res);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid       <= 1'b1;
        s_tdata        <= {3'b000, cp};
        s_tlast        <= last;
        beat_typed     <= typed;
        beat_typed_res <= typed_res;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    // Sender stops until every predicted piece has come out
    task automatic wait_all_pieces();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (piece_q.size() != 0)
            @(posedge aclk);
    endtask

    // Result-side ready: random stalls plus one long hold-off
    always @(posedge aclk) begin
        if (long_hold_req && !long_hold_taken) begin
            long_hold_taken = 1'b1;
            hold_left       = LONG_HOLD;
        end
        if (hold_left != 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Prediction on input beats, checking on result beats, quiet watchdog
    always @(posedge aclk) begin : scoreboard
        piece_res_t  want;
        piece_res_t  got;
        split_mode_e nxt;
        logic        moved;
        moved = 1'b0;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                moved = 1'b1;
                want  = split_piece(s_tdata[20:0], s_tlast, split_st, nxt);
                split_st = nxt;
                if (beat_typed)
                    want = beat_typed_res;
                piece_q = {piece_q, want};
            end
            if (m_tvalid && m_tready) begin
                moved       = 1'b1;
                got.start   = m_tdata[0];
                got.kind    = kind_t'(m_tuser);
                got.seg_end = m_tlast;
                if (piece_q.size() == 0) begin
                    $error("result beat with no piece pending: start %0d kind %0d end %0d",
                           got.start, got.kind, got.seg_end);
                    mismatches++;
                end else begin
                    want = piece_q.pop_front();
                    if (got.start !== want.start) begin
                        $error("piece_start: expected %0d, got %0d", want.start, got.start);
                        mismatches++;
                    end
                    if (got.kind !== want.kind) begin
                        $error("char_kind: expected %0d, got %0d", want.kind, got.kind);
                        mismatches++;
                    end
                    if (got.seg_end !== want.seg_end) begin
                        $error("segment_end: expected %0d, got %0d", want.seg_end, got.seg_end);
                        mismatches++;
                    end
                end
            end
        end
        quiet_cycles = moved ? 0 : quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("** pretokenizer_piece_splitter: FAILED **");
            $finish;
        end
    end

    // Stimulus
    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed table, no idling
        for (int i = 0; i < DIR_ROWS; i++)
            send_code_point(DIRECTED[i].cp, DIRECTED[i].last, DIRECTED[i].typed,
                            DIRECTED[i].res);
        wait_all_pieces();

        // Random segments under four idling patterns
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct <= 0;  recv_stall_pct <= 0;  end
                1: begin send_idle_pct <= 64; recv_stall_pct <= 0;  end
                2: begin send_idle_pct <= 0;  recv_stall_pct <= 64; end
                default: begin send_idle_pct <= 12; recv_stall_pct <= 12; end
            endcase
            @(posedge aclk);
            for (int n = 0; n < RANDOM_ITEMS / 4; n++) begin
                // Long receiver hold-off while the sender keeps pushing
                if (phase == 0 && n == 100)
                    long_hold_req <= 1'b1;
                send_code_point(text_code_point(), ($urandom_range(9) == 0), 1'b0, NO_RES);
            end
            wait_all_pieces();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && piece_q.size() == 0)
            $display("** pretokenizer_piece_splitter: PASSED **");
        else
            $display("** pretokenizer_piece_splitter: FAILED **");
        $finish;
    end

endmodule
